>>> rtl/wrmv_pkg.sv
package wrmv_pkg;

	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [63:0] MAX64 = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONE24 = 64'h0000_0000_0100_0000;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_VARIANCE_ENABLE = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BINNING_ENABLE = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_BIN = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_PRODUCT_MODE = 8'd3;

	typedef enum logic [1:0] {
		MD_MUL,
		MD_SHR24,
		MD_DIV
	} md_kind_t;

	typedef struct packed {
		logic start;
		md_kind_t kind;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] d;
	} md_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [63:0] result;
	} md_rsp_t;

	typedef struct packed {
		logic variance_enable;
		logic binning_enable;
		logic [15:0] samples_per_bin;
		logic product_mode;
	} cfg_t;

	typedef struct packed {
		logic clear;
		logic is_new;
		logic in_range;
		logic [7:0] element;
		logic signed [31:0] value_re;
		logic signed [31:0] value_im;
		logic [31:0] weight;
		logic signed [31:0] scalar_re;
		logic signed [31:0] scalar_im;
		logic last_element;
	} item_t;

	typedef struct packed {
		logic signed [31:0] mean_re;
		logic signed [31:0] mean_im;
		logic [47:0] variance_sum;
		logic [47:0] binned_variance_sum;
		logic bin_closed;
	} result_t;

endpackage

>>> rtl/weighted_running_mean_variance_top.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_stall     operation, element, value, weight, scalar, last
// out      output     out_valid / out_stall   mean, variance_sum, binned_variance_sum, bin_closed
// cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A request's time is set by the shared serial multiply-divide unit, which works on one
// operation at a time; a request with variance off needs fewer operations than one that
// closes a bin. A clear or an element out of range does not use that unit.
// After reset and after every clear, a clearing pass of one element per cycle runs
// before the next request is worked on; up to three requests wait in the front and queue meanwhile.
// A result waits in the output register while the front keeps taking requests.
module weighted_running_mean_variance_top #(
	parameter int ELEMENTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic operation,
	input logic [7:0] element,
	input logic signed [31:0] value_re,
	input logic signed [31:0] value_im,
	input logic [31:0] weight,
	input logic signed [31:0] scalar_re,
	input logic signed [31:0] scalar_im,
	input logic last_element,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] mean_re,
	output logic signed [31:0] mean_im,
	output logic [47:0] variance_sum,
	output logic [47:0] binned_variance_sum,
	output logic bin_closed,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [wrmv_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [wrmv_pkg::CFG_DATA_W-1:0] cfg_data
);

	wrmv_pkg::cfg_t cfg_q;
	wrmv_pkg::item_t push_item;
	wrmv_pkg::item_t pop_item;
	wrmv_pkg::result_t res;
	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.variance_enable <= 1'b0;
			cfg_q.binning_enable <= 1'b0;
			cfg_q.samples_per_bin <= 16'd1;
			cfg_q.product_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wrmv_pkg::REG_VARIANCE_ENABLE: cfg_q.variance_enable <= cfg_data[0];
				wrmv_pkg::REG_BINNING_ENABLE: cfg_q.binning_enable <= cfg_data[0];
				wrmv_pkg::REG_SAMPLES_PER_BIN: cfg_q.samples_per_bin <= cfg_data;
				wrmv_pkg::REG_PRODUCT_MODE: cfg_q.product_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	wrmv_front #(
		.ELEMENTS(ELEMENTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.element(element),
		.value_re(value_re),
		.value_im(value_im),
		.weight(weight),
		.scalar_re(scalar_re),
		.scalar_im(scalar_im),
		.last_element(last_element),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	wrmv_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(push_item),
		.full(q_full),
		.pop(q_pop),
		.pop_item(pop_item),
		.empty(q_empty)
	);

	wrmv_back #(
		.ELEMENTS(ELEMENTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_item(pop_item),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.res(res),
		.out_valid(out_valid),
		.out_stall(out_stall)
	);

	assign mean_re = res.mean_re;
	assign mean_im = res.mean_im;
	assign variance_sum = res.variance_sum;
	assign binned_variance_sum = res.binned_variance_sum;
	assign bin_closed = res.bin_closed;

endmodule

>>> rtl/wrmv_front.sv
module wrmv_front #(
	parameter int ELEMENTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic operation,
	input logic [7:0] element,
	input logic signed [31:0] value_re,
	input logic signed [31:0] value_im,
	input logic [31:0] weight,
	input logic signed [31:0] scalar_re,
	input logic signed [31:0] scalar_im,
	input logic last_element,
	input logic q_full,
	output logic q_push,
	output wrmv_pkg::item_t q_item
);

	wrmv_pkg::item_t item_s1;
	logic valid_s1;
	logic accept;

	assign in_stall = valid_s1 && q_full;
	assign accept = in_valid && !in_stall;
	assign q_push = valid_s1 && !q_full;
	assign q_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				item_s1.clear <= operation;
				item_s1.is_new <= (element == 8'd0);
				item_s1.in_range <= (32'(element) < ELEMENTS);
				item_s1.element <= element;
				item_s1.value_re <= value_re;
				item_s1.value_im <= value_im;
				item_s1.weight <= weight;
				item_s1.scalar_re <= scalar_re;
				item_s1.scalar_im <= scalar_im;
				item_s1.last_element <= last_element;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/wrmv_queue.sv
module wrmv_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input wrmv_pkg::item_t push_item,
	output logic full,
	input logic pop,
	output wrmv_pkg::item_t pop_item,
	output logic empty
);

	wrmv_pkg::item_t buf_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign pop_item = buf_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push && !full) begin
				buf_q[wptr_q] <= push_item;
				wptr_q <= !wptr_q;
			end
			if (pop && !empty) begin
				rptr_q <= !rptr_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/wrmv_muldiv.sv
module wrmv_muldiv (
	input logic clk,
	input logic arst_n,
	input wrmv_pkg::md_req_t req,
	output wrmv_pkg::md_rsp_t rsp
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_MUL,
		M_CHK,
		M_DIV,
		M_FIN
	} mstate_t;

	mstate_t state_q;
	logic [5:0] cnt_q;
	logic [63:0] a_q;
	logic [63:0] d_q;
	logic [63:0] hi_q;
	logic [63:0] lo_q;
	logic [63:0] res_q;
	wrmv_pkg::md_kind_t kind_q;
	logic done_q;

	logic [64:0] sum;
	logic [64:0] rr;
	logic [64:0] rdiff;
	logic ge;

	always_comb begin
		sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : 65'd0);
		rr = {hi_q, lo_q[63]};
		ge = (rr >= {1'b0, d_q});
		rdiff = rr - {1'b0, d_q};
	end

	assign rsp.busy = (state_q != M_IDLE);
	assign rsp.done = done_q;
	assign rsp.result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q <= 6'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q <= req.a;
						d_q <= req.d;
						hi_q <= 64'd0;
						lo_q <= req.b;
						kind_q <= req.kind;
						cnt_q <= 6'd0;
						state_q <= M_MUL;
					end
				end
				M_MUL: begin
					hi_q <= sum[64:1];
					lo_q <= {sum[0], lo_q[63:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= M_CHK;
					end
				end
				M_CHK: begin
					unique case (kind_q)
						wrmv_pkg::MD_MUL: begin
							res_q <= (hi_q == 64'd0) ? lo_q : wrmv_pkg::MAX64;
							done_q <= 1'b1;
							state_q <= M_IDLE;
						end
						wrmv_pkg::MD_SHR24: begin
							res_q <= (hi_q[63:24] == 40'd0) ? {hi_q[23:0], lo_q[63:24]}
								: wrmv_pkg::MAX64;
							done_q <= 1'b1;
							state_q <= M_IDLE;
						end
						wrmv_pkg::MD_DIV: begin
							if (d_q == 64'd0) begin
								res_q <= ((hi_q | lo_q) == 64'd0) ? 64'd0 : wrmv_pkg::MAX64;
								done_q <= 1'b1;
								state_q <= M_IDLE;
							end else if (hi_q >= d_q) begin
								res_q <= wrmv_pkg::MAX64;
								done_q <= 1'b1;
								state_q <= M_IDLE;
							end else begin
								cnt_q <= 6'd0;
								state_q <= M_DIV;
							end
						end
						default: begin
							res_q <= wrmv_pkg::MAX64;
							done_q <= 1'b1;
							state_q <= M_IDLE;
						end
					endcase
				end
				M_DIV: begin
					hi_q <= ge ? rdiff[63:0] : rr[63:0];
					lo_q <= {lo_q[62:0], ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= M_FIN;
					end
				end
				M_FIN: begin
					res_q <= lo_q;
					done_q <= 1'b1;
					state_q <= M_IDLE;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/wrmv_back.sv
module wrmv_back #(
	parameter int ELEMENTS = 256
) (
	input logic clk,
	input logic arst_n,
	input wrmv_pkg::cfg_t cfg,
	input wrmv_pkg::item_t q_item,
	input logic q_empty,
	output logic q_pop,
	output wrmv_pkg::result_t res,
	output logic out_valid,
	input logic out_stall
);

	localparam int DEPTH = (ELEMENTS < 256) ? ELEMENTS : 256;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef struct packed {
		logic signed [31:0] mean_re;
		logic signed [31:0] mean_im;
		logic [47:0] dev;
		logic signed [47:0] acc_re;
		logic signed [47:0] acc_im;
		logic signed [31:0] bmean_re;
		logic signed [31:0] bmean_im;
		logic [47:0] bdev;
	} word_t;

	typedef enum logic [4:0] {
		S_SWEEP, S_IDLE, S_SQ, S_NEW, S_P0, S_P1, S_P2, S_P3, S_X,
		S_NR, S_NI, S_D1, S_D2, S_D3, S_AR, S_AI, S_BR, S_BI,
		S_QR, S_QI, S_E1, S_E2, S_E3, S_WB
	} state_t;

	function automatic logic [63:0] mag_diff(input logic signed [31:0] x,
		input logic signed [31:0] m);
		logic signed [32:0] dd;
		logic [32:0] mg;
		begin
			dd = 33'(x) - 33'(m);
			mg = dd[32] ? 33'(-dd) : 33'(dd);
			return 64'(mg);
		end
	endfunction

	function automatic logic signed [31:0] step_mean(input logic signed [31:0] m,
		input logic signed [31:0] x, input logic [63:0] q);
		logic signed [32:0] dd;
		logic [32:0] mg;
		logic [32:0] inc;
		logic [32:0] sum;
		begin
			dd = 33'(x) - 33'(m);
			mg = dd[32] ? 33'(-dd) : 33'(dd);
			inc = (q > 64'(mg)) ? mg : q[32:0];
			sum = dd[32] ? (33'(m) - inc) : (33'(m) + inc);
			return sum[31:0];
		end
	endfunction

	function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [63:0] b);
		logic [64:0] s;
		begin
			s = 65'(a) + 65'(b);
			return (s > 65'(wrmv_pkg::MAX48)) ? wrmv_pkg::MAX48 : s[47:0];
		end
	endfunction

	function automatic logic signed [47:0] add_s48(input logic signed [47:0] a,
		input logic neg, input logic [63:0] m);
		logic signed [63:0] s;
		begin
			s = 64'(a) + (neg ? -$signed(m) : $signed(m));
			if (s > 64'sh0000_7FFF_FFFF_FFFF) begin
				return 48'sh7FFF_FFFF_FFFF;
			end else if (s < -64'sh0000_8000_0000_0000) begin
				return 48'sh8000_0000_0000;
			end
			return s[47:0];
		end
	endfunction

	function automatic logic signed [31:0] signed_sat32(input logic neg, input logic [63:0] m);
		begin
			if (neg) begin
				return (m >= 64'h8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
			end
			return (m >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		begin
			if (v > 64'sh7FFF_FFFF) begin
				return 32'sh7FFF_FFFF;
			end else if (v < -64'sh8000_0000) begin
				return 32'sh8000_0000;
			end
			return v[31:0];
		end
	endfunction

	state_t state_q;
	logic [AW-1:0] sweep_q;
	wrmv_pkg::item_t item_q;
	word_t mem [DEPTH];
	word_t rd_q;
	word_t wrk_q;
	logic [47:0] tw_q;
	logic [63:0] tws_q;
	logic [31:0] cnt_q;
	logic [15:0] sib_q;
	logic [47:0] bw_q;
	logic [63:0] wsq_q;
	logic signed [63:0] prod_q [4];
	logic signed [31:0] xr_q;
	logic signed [31:0] xi_q;
	logic signed [31:0] br_q;
	logic signed [31:0] bi_q;
	logic [63:0] t_q;
	logic closed_q;
	logic launched_q;
	logic out_valid_q;
	wrmv_pkg::result_t res_q;

	wrmv_pkg::md_req_t md_req;
	wrmv_pkg::md_rsp_t md_rsp;

	logic binning;
	logic [15:0] spb;
	logic bin_full;
	logic [AW-1:0] addr;
	logic out_free;
	logic md_state;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	word_t mem_wd;
	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] prod;
	logic [15:0] sib_base;
	logic [47:0] bw_base;
	logic [15:0] sib_inc;
	logic [47:0] bw_add;
	logic [47:0] tw_add;
	logic [64:0] tws_sum;

	assign binning = cfg.variance_enable && cfg.binning_enable;
	assign spb = (cfg.samples_per_bin == 16'd0) ? 16'd1 : cfg.samples_per_bin;
	assign bin_full = (sib_q >= spb);
	assign addr = item_q.element[AW-1:0];
	assign out_free = !out_valid_q || !out_stall;
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign res = res_q;

	assign md_state = (state_q == S_NR) || (state_q == S_NI) || (state_q == S_D1)
		|| (state_q == S_D2) || (state_q == S_D3) || (state_q == S_AR)
		|| (state_q == S_AI) || (state_q == S_BR) || (state_q == S_BI)
		|| (state_q == S_QR) || (state_q == S_QI) || (state_q == S_E1)
		|| (state_q == S_E2) || (state_q == S_E3);

	always_comb begin
		sib_base = (binning && bin_full) ? 16'd0 : sib_q;
		bw_base = (binning && bin_full) ? 48'd0 : bw_q;
		sib_inc = (sib_base != 16'hFFFF) ? (sib_base + 16'd1) : sib_base;
		bw_add = add_sat48(bw_base, 64'(item_q.weight));
		tw_add = add_sat48(tw_q, 64'(item_q.weight));
		tws_sum = 65'(tws_q) + 65'(wsq_q);
	end

	always_comb begin
		mul_a = item_q.scalar_re;
		mul_b = item_q.value_re;
		unique case (state_q)
			S_P1: begin
				mul_a = item_q.scalar_im;
				mul_b = item_q.value_im;
			end
			S_P2: begin
				mul_a = item_q.scalar_im;
				mul_b = item_q.value_re;
			end
			S_P3: begin
				mul_a = item_q.scalar_re;
				mul_b = item_q.value_im;
			end
			default: begin
				mul_a = item_q.scalar_re;
				mul_b = item_q.value_re;
			end
		endcase
		prod = mul_a * mul_b;
	end

	always_comb begin
		md_req.start = md_state && !launched_q;
		md_req.kind = wrmv_pkg::MD_DIV;
		md_req.a = 64'd0;
		md_req.b = 64'd0;
		md_req.d = 64'd0;
		unique case (state_q)
			S_NR: begin
				md_req.a = mag_diff(xr_q, wrk_q.mean_re);
				md_req.b = 64'(item_q.weight);
				md_req.d = 64'(tw_q);
			end
			S_NI: begin
				md_req.a = mag_diff(xi_q, wrk_q.mean_im);
				md_req.b = 64'(item_q.weight);
				md_req.d = 64'(tw_q);
			end
			S_D1: begin
				md_req.kind = wrmv_pkg::MD_MUL;
				md_req.a = mag_diff(xr_q, wrk_q.mean_re);
				md_req.b = mag_diff(xr_q, rd_q.mean_re);
			end
			S_D2: begin
				md_req.kind = wrmv_pkg::MD_MUL;
				md_req.a = mag_diff(xi_q, wrk_q.mean_im);
				md_req.b = mag_diff(xi_q, rd_q.mean_im);
			end
			S_D3: begin
				md_req.kind = wrmv_pkg::MD_SHR24;
				md_req.a = t_q;
				md_req.b = 64'(item_q.weight);
			end
			S_AR: begin
				md_req.kind = wrmv_pkg::MD_SHR24;
				md_req.a = mag_diff(xr_q, 32'sd0);
				md_req.b = 64'(item_q.weight);
			end
			S_AI: begin
				md_req.kind = wrmv_pkg::MD_SHR24;
				md_req.a = mag_diff(xi_q, 32'sd0);
				md_req.b = 64'(item_q.weight);
			end
			S_BR: begin
				md_req.a = wrk_q.acc_re[47] ? 64'(-$signed(49'(wrk_q.acc_re)))
					: 64'(wrk_q.acc_re);
				md_req.b = wrmv_pkg::ONE24;
				md_req.d = 64'(bw_q);
			end
			S_BI: begin
				md_req.a = wrk_q.acc_im[47] ? 64'(-$signed(49'(wrk_q.acc_im)))
					: 64'(wrk_q.acc_im);
				md_req.b = wrmv_pkg::ONE24;
				md_req.d = 64'(bw_q);
			end
			S_QR: begin
				md_req.a = mag_diff(br_q, wrk_q.bmean_re);
				md_req.b = 64'(bw_q);
				md_req.d = 64'(tw_q);
			end
			S_QI: begin
				md_req.a = mag_diff(bi_q, wrk_q.bmean_im);
				md_req.b = 64'(bw_q);
				md_req.d = 64'(tw_q);
			end
			S_E1: begin
				md_req.kind = wrmv_pkg::MD_MUL;
				md_req.a = mag_diff(br_q, wrk_q.bmean_re);
				md_req.b = mag_diff(br_q, rd_q.bmean_re);
			end
			S_E2: begin
				md_req.kind = wrmv_pkg::MD_MUL;
				md_req.a = mag_diff(bi_q, wrk_q.bmean_im);
				md_req.b = mag_diff(bi_q, rd_q.bmean_im);
			end
			S_E3: begin
				md_req.kind = wrmv_pkg::MD_SHR24;
				md_req.a = t_q;
				md_req.b = 64'(bw_q);
			end
			default: begin
				md_req.kind = wrmv_pkg::MD_DIV;
			end
		endcase
	end

	wrmv_muldiv u_muldiv (
		.clk(clk),
		.arst_n(arst_n),
		.req(md_req),
		.rsp(md_rsp)
	);

	always_comb begin
		mem_we = (state_q == S_SWEEP)
			|| ((state_q == S_WB) && out_free && !item_q.clear && item_q.in_range);
		mem_wa = (state_q == S_SWEEP) ? sweep_q : addr;
		mem_wd = (state_q == S_SWEEP) ? '0 : wrk_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_SWEEP;
			sweep_q <= '0;
			tw_q <= 48'd0;
			tws_q <= 64'd0;
			cnt_q <= 32'd0;
			sib_q <= 16'd0;
			bw_q <= 48'd0;
			closed_q <= 1'b0;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!out_stall && !((state_q == S_WB) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			if (md_req.start) begin
				launched_q <= 1'b1;
			end
			if (md_rsp.done) begin
				launched_q <= 1'b0;
			end
			unique case (state_q)
				S_SWEEP: begin
					if (32'(sweep_q) == DEPTH - 1) begin
						state_q <= S_IDLE;
					end else begin
						sweep_q <= sweep_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (!q_empty) begin
						item_q <= q_item;
						closed_q <= 1'b0;
						if (q_item.clear) begin
							state_q <= S_WB;
						end else if (q_item.is_new) begin
							state_q <= S_SQ;
						end else if (q_item.in_range) begin
							state_q <= S_P0;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_SQ: begin
					wsq_q <= 64'(item_q.weight) * 64'(item_q.weight);
					state_q <= S_NEW;
				end
				S_NEW: begin
					cnt_q <= cnt_q + 32'd1;
					tw_q <= tw_add;
					tws_q <= tws_sum[64] ? wrmv_pkg::MAX64 : tws_sum[63:0];
					sib_q <= binning ? sib_inc : sib_base;
					bw_q <= binning ? bw_add : bw_base;
					state_q <= item_q.in_range ? S_P0 : S_WB;
				end
				S_P0: begin
					prod_q[0] <= prod;
					state_q <= S_P1;
				end
				S_P1: begin
					prod_q[1] <= prod;
					state_q <= S_P2;
				end
				S_P2: begin
					prod_q[2] <= prod;
					state_q <= S_P3;
				end
				S_P3: begin
					prod_q[3] <= prod;
					state_q <= S_X;
				end
				S_X: begin
					if (cfg.product_mode) begin
						xr_q <= sat32((prod_q[0] >>> 16) + (prod_q[1] >>> 16));
						xi_q <= sat32((prod_q[2] >>> 16) - (prod_q[3] >>> 16));
					end else begin
						xr_q <= item_q.value_re;
						xi_q <= item_q.value_im;
					end
					wrk_q <= rd_q;
					state_q <= S_NR;
				end
				S_NR: begin
					if (md_rsp.done) begin
						wrk_q.mean_re <= step_mean(wrk_q.mean_re, xr_q, md_rsp.result);
						state_q <= S_NI;
					end
				end
				S_NI: begin
					if (md_rsp.done) begin
						wrk_q.mean_im <= step_mean(wrk_q.mean_im, xi_q, md_rsp.result);
						if (cfg.variance_enable) begin
							state_q <= S_D1;
						end else begin
							state_q <= S_WB;
						end
					end
				end
				S_D1, S_E1: begin
					if (md_rsp.done) begin
						t_q <= md_rsp.result >> 16;
						state_q <= (state_q == S_D1) ? S_D2 : S_E2;
					end
				end
				S_D2, S_E2: begin
					if (md_rsp.done) begin
						t_q <= t_q + (md_rsp.result >> 16);
						state_q <= (state_q == S_D2) ? S_D3 : S_E3;
					end
				end
				S_D3: begin
					if (md_rsp.done) begin
						wrk_q.dev <= add_sat48(wrk_q.dev, md_rsp.result);
						state_q <= binning ? S_AR : S_WB;
					end
				end
				S_AR: begin
					if (md_rsp.done) begin
						wrk_q.acc_re <= add_s48(wrk_q.acc_re, xr_q[31], md_rsp.result);
						state_q <= S_AI;
					end
				end
				S_AI: begin
					if (md_rsp.done) begin
						wrk_q.acc_im <= add_s48(wrk_q.acc_im, xi_q[31], md_rsp.result);
						state_q <= bin_full ? S_BR : S_WB;
					end
				end
				S_BR: begin
					if (md_rsp.done) begin
						br_q <= signed_sat32(wrk_q.acc_re[47], md_rsp.result);
						state_q <= S_BI;
					end
				end
				S_BI: begin
					if (md_rsp.done) begin
						bi_q <= signed_sat32(wrk_q.acc_im[47], md_rsp.result);
						state_q <= S_QR;
					end
				end
				S_QR: begin
					if (md_rsp.done) begin
						wrk_q.bmean_re <= step_mean(wrk_q.bmean_re, br_q, md_rsp.result);
						state_q <= S_QI;
					end
				end
				S_QI: begin
					if (md_rsp.done) begin
						wrk_q.bmean_im <= step_mean(wrk_q.bmean_im, bi_q, md_rsp.result);
						state_q <= S_E1;
					end
				end
				S_E3: begin
					if (md_rsp.done) begin
						wrk_q.bdev <= add_sat48(wrk_q.bdev, md_rsp.result);
						wrk_q.acc_re <= 48'sd0;
						wrk_q.acc_im <= 48'sd0;
						closed_q <= 1'b1;
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (item_q.clear || !item_q.in_range) begin
							res_q <= '0;
						end else begin
							res_q.mean_re <= wrk_q.mean_re;
							res_q.mean_im <= wrk_q.mean_im;
							res_q.variance_sum <= wrk_q.dev;
							res_q.binned_variance_sum <= wrk_q.bdev;
							res_q.bin_closed <= closed_q;
						end
						if (item_q.clear) begin
							tw_q <= 48'd0;
							tws_q <= 64'd0;
							cnt_q <= 32'd0;
							sib_q <= 16'd0;
							bw_q <= 48'd0;
							sweep_q <= '0;
							state_q <= S_SWEEP;
						end else begin
							if (closed_q && item_q.last_element) begin
								sib_q <= 16'd0;
								bw_q <= 48'd0;
							end
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_req.start |-> !md_rsp.busy)
		else $error("divider started while busy");

	a_sweep_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP) |-> !q_pop)
		else $error("request taken during clearing pass");

	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q != S_SWEEP)) |=> out_valid_q)
		else $error("element written without a result");
`endif

endmodule
